// File: design/lzd_pkg.sv
// shared types and constants for the lz77 stream decompressor
// no dependencies; imported by every module of the block
package lzd_pkg;

   localparam int ADDR_W = 24;
   localparam int DATA_W = 16;

   // token and flag decoding
   localparam logic [7:0] FLAG_MSB      = 8'h80;
   localparam logic [2:0] FLAG_LAST_POS = 3'd7;
   localparam logic [4:0] LEN_BIAS      = 5'd3;

   // one request of the compressed stream
   typedef struct packed {
      logic       start_stream;
      logic [7:0] in_byte;
   } req_type;

   // one write produced by the decompressor
   typedef struct packed {
      logic [ADDR_W-1:0] write_address;
      logic [DATA_W-1:0] write_data;
      logic              last_of_run;
      logic              finished;
      logic              bad_reference;
   } rsp_type;

   // write strobes and data for the two history banks
   typedef struct packed {
      logic       we_even;
      logic       we_odd;
      logic [7:0] data_even;
      logic [7:0] data_odd;
   } win_wr_type;

endpackage

// File: design/lzd_window.sv
// history window: two byte-wide banks for even and odd offsets
// uses lzd_pkg for the write control struct
module lzd_window #(
   parameter int ROW_BITS = 11
) (
   input  logic               clock,
   input  lzd_pkg::win_wr_type wr,
   input  logic [ROW_BITS-1:0] wr_row,
   input  logic               rd_en,
   input  logic [ROW_BITS-1:0] rd_row,
   input  logic               rd_odd,
   output logic [7:0]         rd_data
);
   import lzd_pkg::*;

   localparam int ROWS = 1 << ROW_BITS;

   logic [7:0] bank_even_ff [0:ROWS-1];
   logic [7:0] bank_odd_ff  [0:ROWS-1];
   logic [7:0] rd_even_ff;
   logic [7:0] rd_odd_ff;
   logic       odd_sel_ff;

   // even bank, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr.we_even) begin
         bank_even_ff[wr_row] <= wr.data_even;
      end
      if (rd_en) begin
         rd_even_ff <= bank_even_ff[rd_row];
      end
   end

   // odd bank, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr.we_odd) begin
         bank_odd_ff[wr_row] <= wr.data_odd;
      end
      if (rd_en) begin
         rd_odd_ff  <= bank_odd_ff[rd_row];
         odd_sel_ff <= rd_odd;
      end
   end

   // pick the byte of the addressed offset
   assign rd_data = odd_sel_ff ? rd_odd_ff : rd_even_ff;

endmodule

// File: design/lzd_ctrl.sv
// stream parser and copy sequencer of the lz77 decompressor
// uses lzd_pkg; drives the history window ports and the result register
module lzd_ctrl #(
   parameter int SIZE_BITS = 24,
   parameter int WIN_BITS  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cfg_halfword,
   input  logic                  req_valid,
   input  lzd_pkg::req_type      req_data,
   output logic                  req_ready,
   input  logic                  out_ready,
   output logic                  emit_valid,
   output lzd_pkg::rsp_type      emit_data,
   output lzd_pkg::win_wr_type   win_wr,
   output logic [WIN_BITS-2:0]   win_wr_row,
   output logic                  win_rd_en,
   output logic [WIN_BITS-2:0]   win_rd_row,
   output logic                  win_rd_odd,
   input  logic [7:0]            win_rd_data
);
   import lzd_pkg::*;

   localparam int SB       = SIZE_BITS;
   localparam int SRC_BITS = ((SIZE_BITS > WIN_BITS) ? SIZE_BITS : WIN_BITS) + 1;

   typedef enum logic [3:0] {
      S_HDR0, S_HDR1, S_HDR2, S_HDR3, S_FLAG, S_ITEM, S_TOKEN2, S_DONE,
      S_LIT, S_CRD, S_CDAT
   } state_type;

   state_type             state_ff, state_in;
   logic                  hw_ff, hw_in;
   logic [SB-1:0]         total_ff, total_in;
   logic [SB-1:0]         produced_ff, produced_in;
   logic [7:0]            flags_ff, flags_in;
   logic [2:0]            fpos_ff, fpos_in;
   logic [7:0]            tok_ff, tok_in;
   logic [7:0]            held_ff, held_in;
   logic [7:0]            lit_ff, lit_in;
   logic [SRC_BITS-1:0]   src_ff, src_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  bad_ff, bad_in;

   // position of the next output byte, widened for window indexing
   logic [SRC_BITS-1:0]   pos_ext;
   assign pos_ext    = SRC_BITS'(produced_ff);
   assign win_wr_row = pos_ext[WIN_BITS-1:1];
   assign win_rd_row = src_ff[WIN_BITS-1:1];
   assign win_rd_odd = src_ff[0];

   // the stream is taken only in the parse phases
   assign req_ready = (state_ff inside {S_HDR0, S_HDR1, S_HDR2, S_HDR3,
                                        S_FLAG, S_ITEM, S_TOKEN2, S_DONE});

   always_comb begin
      state_type           phase;
      logic [ADDR_W-1:0]   size_w;
      logic [12:0]         back_dist;
      logic [7:0]          value;
      logic [SB:0]         prod_n;
      logic [SB:0]         total_ext;
      logic                reached;
      logic                done_after;
      logic                last_pair;

      state_in    = state_ff;
      hw_in       = hw_ff;
      total_in    = total_ff;
      produced_in = produced_ff;
      flags_in    = flags_ff;
      fpos_in     = fpos_ff;
      tok_in      = tok_ff;
      held_in     = held_ff;
      lit_in      = lit_ff;
      src_in      = src_ff;
      cnt_in      = cnt_ff;
      bad_in      = bad_ff;
      emit_valid  = 1'b0;
      emit_data   = '0;
      win_wr      = '0;
      win_rd_en   = 1'b0;
      size_w      = '0;
      back_dist   = '0;

      // produce-step terms shared by literals and copies
      value      = (state_ff == S_LIT) ? lit_ff :
                   (src_ff[SRC_BITS-1] ? 8'h00 : win_rd_data);
      prod_n     = {1'b0, produced_ff} + 1'b1;
      total_ext  = {1'b0, total_ff};
      reached    = (prod_n >= total_ext);
      done_after = (cnt_ff == 5'd1) || reached;
      last_pair  = done_after || ((cnt_ff == 5'd2) && ((prod_n + 1'b1) < total_ext));

      phase = req_data.start_stream ? S_HDR0 : state_ff;

      if (req_ready) begin
         // one stream byte per accepted request
         if (req_valid) begin
            case (phase)
               S_HDR0: begin
                  hw_in       = cfg_halfword;
                  total_in    = '0;
                  produced_in = '0;
                  flags_in    = '0;
                  fpos_in     = '0;
                  tok_in      = '0;
                  held_in     = '0;
                  state_in    = S_HDR1;
               end
               S_HDR1: begin
                  size_w   = ADDR_W'(req_data.in_byte);
                  total_in = size_w[SB-1:0];
                  state_in = S_HDR2;
               end
               S_HDR2: begin
                  size_w   = ADDR_W'(total_ff) | (ADDR_W'(req_data.in_byte) << 8);
                  total_in = size_w[SB-1:0];
                  state_in = S_HDR3;
               end
               S_HDR3: begin
                  size_w   = ADDR_W'(total_ff) | (ADDR_W'(req_data.in_byte) << 16);
                  total_in = size_w[SB-1:0];
                  state_in = (size_w[SB-1:0] == '0) ? S_DONE : S_FLAG;
               end
               S_FLAG: begin
                  flags_in = req_data.in_byte;
                  fpos_in  = '0;
                  state_in = S_ITEM;
               end
               S_ITEM: begin
                  if ((flags_ff & (FLAG_MSB >> fpos_ff)) != 8'h00) begin
                     tok_in   = req_data.in_byte;
                     state_in = S_TOKEN2;
                  end else begin
                     lit_in   = req_data.in_byte;
                     cnt_in   = 5'd1;
                     bad_in   = 1'b0;
                     src_in   = '0;
                     state_in = S_LIT;
                  end
               end
               S_TOKEN2: begin
                  back_dist = {1'b0, tok_ff[3:0], req_data.in_byte} + 13'd1;
                  src_in    = pos_ext - SRC_BITS'(back_dist);
                  bad_in    = (pos_ext < SRC_BITS'(back_dist));
                  cnt_in    = {1'b0, tok_ff[7:4]} + LEN_BIAS;
                  state_in  = S_CRD;
               end
               S_DONE: begin
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_HDR0;
               end
            endcase
         end
      end else begin
         case (state_ff)
            // read one source byte of the copy
            S_CRD: begin
               win_rd_en = 1'b1;
               state_in  = S_CDAT;
            end
            // produce one output byte, literal or copied
            S_LIT, S_CDAT: begin
               if (out_ready) begin
                  produced_in = prod_n[SB-1:0];
                  cnt_in      = cnt_ff - 5'd1;
                  src_in      = src_ff + 1'b1;
                  emit_data.bad_reference = bad_ff;
                  if (!hw_ff) begin
                     win_wr.we_even  = ~produced_ff[0];
                     win_wr.we_odd   = produced_ff[0];
                     win_wr.data_even = value;
                     win_wr.data_odd  = value;
                     emit_valid = 1'b1;
                     emit_data.write_address = ADDR_W'(produced_ff);
                     emit_data.write_data    = DATA_W'(value);
                     emit_data.finished      = reached;
                     emit_data.last_of_run   = done_after;
                  end else if (produced_ff[0]) begin
                     // odd byte completes the held pair
                     win_wr.we_even   = 1'b1;
                     win_wr.we_odd    = 1'b1;
                     win_wr.data_even = held_ff;
                     win_wr.data_odd  = value;
                     emit_valid = 1'b1;
                     emit_data.write_address = ADDR_W'({produced_ff[SB-1:1], 1'b0});
                     emit_data.write_data    = {value, held_ff};
                     emit_data.finished      = reached;
                     emit_data.last_of_run   = last_pair;
                  end else begin
                     // even byte is held; flushed alone at the end of an odd size
                     held_in = value;
                     if (reached) begin
                        win_wr.we_even   = 1'b1;
                        win_wr.data_even = value;
                        emit_valid = 1'b1;
                        emit_data.write_address = ADDR_W'(produced_ff);
                        emit_data.write_data    = DATA_W'(value);
                        emit_data.finished      = 1'b1;
                        emit_data.last_of_run   = 1'b1;
                     end
                  end
                  // end of the item: stop, next flag byte or next item; otherwise read the next source byte
                  if (done_after) begin
                     if (reached) begin
                        state_in = S_DONE;
                     end else begin
                        fpos_in  = fpos_ff + 3'd1;
                        state_in = (fpos_ff == FLAG_LAST_POS) ? S_FLAG : S_ITEM;
                     end
                  end else begin
                     state_in = S_CRD;
                  end
               end
            end
            default: begin
               state_in = S_HDR0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_HDR0;
         hw_ff       <= 1'b0;
         total_ff    <= '0;
         produced_ff <= '0;
         flags_ff    <= '0;
         fpos_ff     <= '0;
         tok_ff      <= '0;
         held_ff     <= '0;
         cnt_ff      <= '0;
         bad_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         hw_ff       <= hw_in;
         total_ff    <= total_in;
         produced_ff <= produced_in;
         flags_ff    <= flags_in;
         fpos_ff     <= fpos_in;
         tok_ff      <= tok_in;
         held_ff     <= held_in;
         cnt_ff      <= cnt_in;
         bad_ff      <= bad_in;
      end
      lit_ff <= lit_in;
      src_ff <= src_in;
   end

endmodule

// File: design/lz77_stream_decompressor_core.sv
// top level of the lz77 stream decompressor: config register, result register
// uses lzd_pkg, lzd_window and lzd_ctrl
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | lzd_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_stall  | lzd_pkg::rsp_type
//   csr     | in        | csr_write_enable       | csr_write_data (halfword_writes)
//
// header, flag and token first bytes are each taken in their parse state; a literal is taken, then emitted.
// a token's second byte is taken, then each copied byte has a history read through the
// registered window port (S_CRD) followed by a write back and emit (S_CDAT).
// reset (synchronous, active high) clears the parse state; the window needs no clearing.
// a stalled result holds the output register and the sequencer waits on it.
// WINDOW_DEPTH must be a power of two.
module lz77_stream_decompressor_core #(
   parameter int WINDOW_DEPTH = 4096,
   parameter int SIZE_BITS    = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic             csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  lzd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lzd_pkg::rsp_type rsp_data
);
   import lzd_pkg::*;

   localparam int WIN_BITS = $clog2(WINDOW_DEPTH);
   localparam int ROW_BITS = WIN_BITS - 1;

   logic                cfg_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   logic                req_ready;
   logic                out_ready;
   logic                emit_valid;
   rsp_type             emit_data;
   win_wr_type          win_wr;
   logic [ROW_BITS-1:0] win_wr_row;
   logic                win_rd_en;
   logic [ROW_BITS-1:0] win_rd_row;
   logic                win_rd_odd;
   logic [7:0]          win_rd_data;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= 1'b0;
      end else if (csr_write_enable) begin
         cfg_ff <= csr_write_data;
      end
   end

   // result register, refilled in the cycle it is taken
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_valid) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_stall = ~req_ready;

   lzd_window #(
      .ROW_BITS (ROW_BITS)
   ) u_window (
      .clock   (clock),
      .wr      (win_wr),
      .wr_row  (win_wr_row),
      .rd_en   (win_rd_en),
      .rd_row  (win_rd_row),
      .rd_odd  (win_rd_odd),
      .rd_data (win_rd_data)
   );

   lzd_ctrl #(
      .SIZE_BITS (SIZE_BITS),
      .WIN_BITS  (WIN_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg_halfword (cfg_ff),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_ready    (req_ready),
      .out_ready    (out_ready),
      .emit_valid   (emit_valid),
      .emit_data    (emit_data),
      .win_wr       (win_wr),
      .win_wr_row   (win_wr_row),
      .win_rd_en    (win_rd_en),
      .win_rd_row   (win_rd_row),
      .win_rd_odd   (win_rd_odd),
      .win_rd_data  (win_rd_data)
   );

endmodule

// File: dv/lz77_stream_decompressor_core_test.sv
// self-checking testbench for lz77_stream_decompressor_core: opening table, then random streams
// depends on lzd_pkg and the core; a built-in decoder model predicts the writes, typed table rows give their own
`timescale 1ns / 1ps

module lz77_stream_decompressor_core_test;
   import lzd_pkg::*;

   localparam int WIN_BITS        = 12;
   localparam int WIN             = 1 << WIN_BITS;
   localparam int RANDOM_ITEMS    = 150;
   localparam int SETTLE_CYCLES   = 48;
   localparam int LONG_HOLD       = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRESSURE_AT     = 60;

   typedef enum logic [2:0] {
      PH_HDR0, PH_SIZE0, PH_SIZE1, PH_SIZE2, PH_FLAGS, PH_ITEM, PH_TOKEN, PH_END
   } parse_state_type;

   // one line of the opening table
   typedef struct packed {
      logic    halfword;
      logic    start;
      logic [7:0] data;
      logic    typed;
      rsp_type want;
   } stream_row_type;

   localparam stream_row_type OPENING [0:28] = '{
      // byte mode: size 3, literal then a clipped copy, then trailing input
      '{1'b0, 1'b1, 8'h10, 1'b0, '0},
      '{1'b0, 1'b0, 8'h03, 1'b0, '0},
      '{1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 1'b0, 8'h40, 1'b0, '0},
      '{1'b0, 1'b0, 8'hFF, 1'b1, '{24'd0, 16'h00FF, 1'b1, 1'b0, 1'b0}},
      '{1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 1'b0, 8'h5A, 1'b0, '0},
      // zero size, then ignored input
      '{1'b0, 1'b1, 8'hFF, 1'b0, '0},
      '{1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 1'b0, 8'h77, 1'b0, '0},
      // largest size, longest copy from before the start of the output
      '{1'b0, 1'b1, 8'h10, 1'b0, '0},
      '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
      '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
      '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
      '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
      '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
      '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
      // halfword mode, odd size: pair then flushed last byte
      '{1'b1, 1'b1, 8'h10, 1'b0, '0},
      '{1'b1, 1'b0, 8'h03, 1'b0, '0},
      '{1'b1, 1'b0, 8'h00, 1'b0, '0},
      '{1'b1, 1'b0, 8'h00, 1'b0, '0},
      '{1'b1, 1'b0, 8'h00, 1'b0, '0},
      '{1'b1, 1'b0, 8'h12, 1'b0, '0},
      '{1'b1, 1'b0, 8'h34, 1'b1, '{24'd0, 16'h3412, 1'b1, 1'b0, 1'b0}},
      '{1'b1, 1'b0, 8'h56, 1'b1, '{24'd2, 16'h0056, 1'b1, 1'b1, 1'b0}}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data = 1'b0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // decoder model state
   logic [7:0]      hist [WIN];
   bit              hist_valid [WIN];
   parse_state_type phase = PH_HDR0;
   logic [23:0]     size_total = '0;
   logic [23:0]     out_count = '0;
   logic [7:0]      flag_byte = '0;
   logic [7:0]      tok_first = '0;
   logic [7:0]      held_byte = '0;
   int              flag_pos = 0;
   bit              cfg_halfword = 1'b0;
   bit              stream_halfword = 1'b0;

   rsp_type step_writes [$];
   rsp_type pending_writes [$];

   bit      typed_on = 1'b0;
   rsp_type typed_write = '0;
   bit      long_hold = 1'b0;
   int      mismatch_count = 0;
   int      quiet_cycles = 0;
   int      send_calm = 0;
   int      take_calm = 0;

   lz77_stream_decompressor_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   always #2 clock = ~clock;

   // ---------------- decoder model ----------------

   task automatic clear_stream();
      phase = PH_HDR0;
      size_total = '0;
      out_count = '0;
      flag_byte = '0;
      flag_pos = 0;
      tok_first = '0;
      held_byte = '0;
      stream_halfword = 1'b0;
   endtask

   task automatic emit_write(input logic [23:0] addr, input logic [15:0] data, input bit bad);
      rsp_type w;
      w.write_address = addr;
      w.write_data    = data;
      w.last_of_run   = 1'b0;
      w.finished      = (out_count >= size_total);
      w.bad_reference = bad;
      step_writes.push_back(w);
   endtask

   // one output byte: straight out, or held until its odd partner comes
   task automatic put_byte(input logic [7:0] v, input bit bad);
      logic [23:0] pos;
      logic [23:0] even;
      pos = out_count;
      even = pos - 24'd1;
      out_count = pos + 24'd1;
      if (!stream_halfword) begin
         hist[pos[WIN_BITS-1:0]] = v;
         hist_valid[pos[WIN_BITS-1:0]] = 1'b1;
         emit_write(pos, {8'h00, v}, bad);
      end else if (!pos[0]) begin
         held_byte = v;
      end else begin
         hist[even[WIN_BITS-1:0]] = held_byte;
         hist_valid[even[WIN_BITS-1:0]] = 1'b1;
         hist[pos[WIN_BITS-1:0]] = v;
         hist_valid[pos[WIN_BITS-1:0]] = 1'b1;
         emit_write(even, {v, held_byte}, bad);
      end
   endtask

   // after a literal or a copy: finish the stream or move to the next flag bit
   task automatic close_item(input bit bad);
      logic [23:0] even;
      if (out_count >= size_total) begin
         if (stream_halfword && out_count[0]) begin
            even = out_count - 24'd1;
            hist[even[WIN_BITS-1:0]] = held_byte;
            hist_valid[even[WIN_BITS-1:0]] = 1'b1;
            emit_write(even, {8'h00, held_byte}, bad);
         end
         phase = PH_END;
      end else begin
         flag_pos++;
         phase = (flag_pos >= 8) ? PH_FLAGS : PH_ITEM;
      end
   endtask

   task automatic decode_byte(input req_type r);
      int count;
      int back_dist;
      int src;
      int s;
      logic [7:0] v;
      bit bad;
      rsp_type w;
      step_writes.delete();
      if (r.start_stream) clear_stream();
      case (phase)
         PH_HDR0: begin
            stream_halfword = cfg_halfword;
            phase = PH_SIZE0;
         end
         PH_SIZE0: begin
            size_total[7:0] = r.in_byte;
            phase = PH_SIZE1;
         end
         PH_SIZE1: begin
            size_total[15:8] = r.in_byte;
            phase = PH_SIZE2;
         end
         PH_SIZE2: begin
            size_total[23:16] = r.in_byte;
            phase = (size_total == 24'd0) ? PH_END : PH_FLAGS;
         end
         PH_FLAGS: begin
            flag_byte = r.in_byte;
            flag_pos = 0;
            phase = PH_ITEM;
         end
         PH_ITEM: begin
            if ((flag_byte & (FLAG_MSB >> (flag_pos % 8))) != 8'h00) begin
               tok_first = r.in_byte;
               phase = PH_TOKEN;
            end else begin
               put_byte(r.in_byte, 1'b0);
               close_item(1'b0);
            end
         end
         PH_TOKEN: begin
            count = int'(tok_first[7:4]) + int'(LEN_BIAS);
            back_dist = int'({tok_first[3:0], r.in_byte}) + 1;
            src = int'(out_count) - back_dist;
            bad = (src < 0);
            for (int i = 0; i < count && out_count < size_total; i++) begin
               s = src + i;
               v = (s >= 0) ? hist[s[WIN_BITS-1:0]] : 8'h00;
               put_byte(v, bad);
            end
            close_item(bad);
         end
         default: ;
      endcase
      // mark the final write of this request
      if (step_writes.size() > 0) begin
         w = step_writes.pop_back();
         w.last_of_run = 1'b1;
         step_writes.push_back(w);
      end
   endtask

   // ---------------- checking ----------------

   task automatic note_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         mismatch_count++;
         $display("mismatch %s: got %0h, expected %0h", name, got, want);
      end
   endtask

   // results, configuration and requests, all sampled at the rising edge
   always @(posedge clock) begin : observe
      rsp_type w;
      bit busy;
      busy = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            if (pending_writes.size() == 0) begin
               note_field("write with nothing expected", 1, 0);
            end else begin
               w = pending_writes.pop_front();
               note_field("write_address", 32'(rsp_data.write_address),
                          32'(w.write_address));
               note_field("write_data", 32'(rsp_data.write_data), 32'(w.write_data));
               note_field("last_of_run", 32'(rsp_data.last_of_run), 32'(w.last_of_run));
               note_field("finished", 32'(rsp_data.finished), 32'(w.finished));
               note_field("bad_reference", 32'(rsp_data.bad_reference),
                          32'(w.bad_reference));
            end
         end
         if (csr_write_enable) cfg_halfword = csr_write_data;
         if (req_valid && !req_stall) begin
            busy = 1'b1;
            decode_byte(req_data);
            if (typed_on) pending_writes.push_back(typed_write);
            else foreach (step_writes[i]) pending_writes.push_back(step_writes[i]);
         end
      end
      // watchdog on cycles with no handshake at all
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   // offer one request, after a random gap, and wait for it to be taken
   task automatic offer(input logic start, input logic [7:0] b);
      int gap;
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 13);
         if ($urandom_range(0, 9) == 0) send_calm = $urandom_range(10, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= '{start_stream: start, in_byte: b};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // let every expected write arrive, then give the block time to go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(input bit halfword);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= halfword;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // would a copy of len bytes from back_dist back only read window entries already written
   function automatic bit copy_fits(input int len, input int back_dist);
      int p;
      int s;
      int base;
      logic [31:0] fresh;
      base = int'(out_count) - 1;
      p = int'(out_count);
      fresh = '0;
      for (int i = 0; i < len && p < int'(size_total); i++) begin
         s = int'(out_count) - back_dist + i;
         if (s >= 0 && !hist_valid[s[WIN_BITS-1:0]] && !(s >= base && fresh[s - base]))
            return 1'b0;
         if (!stream_halfword) begin
            fresh[p - base] = 1'b1;
         end else if (p % 2 == 1) begin
            fresh[p - 1 - base] = 1'b1;
            fresh[p - base] = 1'b1;
         end
         p++;
      end
      return 1'b1;
   endfunction

   // random copy token, mostly reaching into recent output
   task automatic pick_token(output logic [7:0] tok_a, output logic [7:0] tok_b);
      int len;
      int back_dist;
      int reach;
      bit found;
      logic [11:0] code;
      len = $urandom_range(0, 15);
      reach = (int'(out_count) + 2 > WIN) ? WIN : int'(out_count) + 2;
      found = 1'b0;
      back_dist = WIN;
      for (int t = 0; t < 40 && !found; t++) begin
         back_dist = ($urandom_range(0, 3) == 0) ? $urandom_range(1, WIN)
                                                 : $urandom_range(1, reach);
         found = copy_fits(len + 3, back_dist);
      end
      // fall back to a copy entirely before the start of the output
      if (!found) back_dist = WIN;
      code = 12'(back_dist - 1);
      tok_a = {len[3:0], code[11:8]};
      tok_b = code[7:0];
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin : take_results
      int hold;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold) begin
            hold = LONG_HOLD;
            long_hold = 1'b0;
         end else if (take_calm > 0) begin
            take_calm--;
            hold = 0;
         end else begin
            hold = $urandom_range(0, 13);
            if ($urandom_range(0, 9) == 0) take_calm = $urandom_range(10, 30);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : drive_requests
      int done_items;
      int stream_len;
      bit fresh_stream;
      bit pressure_done;
      logic start;
      logic [7:0] b;
      logic [23:0] plan_size;
      logic [7:0] plan_second;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // opening table
      for (int i = 0; i < $size(OPENING); i++) begin
         if (i == 0 || OPENING[i].halfword != OPENING[i-1].halfword)
            set_mode(OPENING[i].halfword);
         typed_on = OPENING[i].typed;
         typed_write = OPENING[i].want;
         offer(OPENING[i].start, OPENING[i].data);
      end
      typed_on = 1'b0;

      // random streams with some trailing input and abandoned streams
      done_items = 0;
      stream_len = 0;
      fresh_stream = 1'b1;
      pressure_done = 1'b0;
      plan_size = '0;
      plan_second = '0;
      while (done_items < RANDOM_ITEMS) begin
         if (done_items >= PRESSURE_AT && !pressure_done) begin
            long_hold = 1'b1;
            pressure_done = 1'b1;
         end
         start = 1'b0;
         b = 8'($urandom_range(0, 255));
         if (!fresh_stream && (stream_len > 80 || $urandom_range(0, 59) == 0))
            fresh_stream = 1'b1;
         if (phase == PH_END && !fresh_stream && $urandom_range(0, 2) != 0)
            fresh_stream = 1'b1;
         if (fresh_stream) begin
            if ($urandom_range(0, 3) == 0) set_mode(1'($urandom_range(0, 1)));
            case ($urandom_range(0, 15))
               0:       plan_size = '0;
               1:       plan_size = 24'($urandom_range(120, 300));
               2:       plan_size = 24'hFFFFFF;
               default: plan_size = 24'($urandom_range(1, 24));
            endcase
            start = 1'b1;
            fresh_stream = 1'b0;
            stream_len = 0;
         end else begin
            case (phase)
               PH_SIZE0: b = plan_size[7:0];
               PH_SIZE1: b = plan_size[15:8];
               PH_SIZE2: b = plan_size[23:16];
               PH_FLAGS: begin
                  case ($urandom_range(0, 3))
                     0:       b = 8'h00;
                     1:       b = 8'hFF;
                     default: ;
                  endcase
               end
               PH_ITEM: begin
                  if ((flag_byte & (FLAG_MSB >> (flag_pos % 8))) != 8'h00)
                     pick_token(b, plan_second);
               end
               PH_TOKEN: b = plan_second;
               default: ;
            endcase
         end
         if (start || phase != PH_END) done_items++;
         stream_len++;
         offer(start, b);
      end

      settle();
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
